>>> design/kpc_pkg.sv
package kpc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int RATIO_BITS = FRAC_BITS + 1;
    localparam int CLIP_BITS = 8;
    localparam logic [RATIO_BITS-1:0] Q_ONE = RATIO_BITS'(1) << FRAC_BITS;

    localparam logic CH_CUR = 1'b0;
    localparam logic CH_PREV = 1'b1;
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_ADD,
        S_MOD,
        S_MUL,
        S_DIV,
        S_POS,
        S_FADE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic in_load;
        logic decide;
        logic add;
        logic div_step;
        logic mul;
        logic pos;
        logic fade;
        logic out_load;
        logic sel;
    } t_cmd;

    typedef struct packed {
        logic command;
        logic frozen;
        logic wrap;
        logic div_last;
        logic fading;
    } t_stat;

endpackage

>>> design/kpc_ctrl.sv
module kpc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    input  kpc_pkg::t_stat i_stat,
    output kpc_pkg::t_cmd  o_cmd
);
    import kpc_pkg::*;

    t_state r_state, n_state;
    logic   r_sel, n_sel;
    logic   r_ovalid, n_ovalid;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sel    <= CH_CUR;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sel    <= n_sel;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        cmd     = '0;
        cmd.sel = r_sel;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.in_load = 1'b1;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                if (i_stat.command == CMD_START) begin
                    n_state = S_OUT;
                end else begin
                    n_sel   = CH_CUR;
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                cmd.add = 1'b1;
                if (i_stat.frozen) begin
                    if (r_sel == CH_CUR && i_stat.fading) begin
                        n_sel   = CH_PREV;
                        n_state = S_ADD;
                    end else begin
                        n_state = S_FADE;
                    end
                end else if (i_stat.wrap) begin
                    n_state = S_MOD;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MOD: begin
                cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_POS;
                end
            end
            S_POS: begin
                cmd.pos = 1'b1;
                if (r_sel == CH_CUR && i_stat.fading) begin
                    n_sel   = CH_PREV;
                    n_state = S_ADD;
                end else begin
                    n_state = S_FADE;
                end
            end
            S_FADE: begin
                cmd.fade = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_ovalid = cmd.out_load ? 1'b1 : (r_ovalid && i_stall);
    end

    assign o_cmd   = cmd;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;

endmodule

>>> design/kpc_dp.sv
module kpc_dp #(
    parameter int TIME_BITS  = 24,
    parameter int FRAME_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  kpc_pkg::t_cmd                    i_cmd,
    output kpc_pkg::t_stat                   o_stat,
    input  logic                             i_command,
    input  logic [TIME_BITS-1:0]             i_delta_time,
    input  logic [kpc_pkg::CLIP_BITS-1:0]    i_clip_id,
    input  logic [TIME_BITS-1:0]             i_clip_length,
    input  logic [FRAME_BITS-1:0]            i_clip_frames,
    input  logic                             i_loop_enable,
    input  logic [TIME_BITS-1:0]             i_fade_time,
    output logic                             o_start_ignored,
    output logic [kpc_pkg::CLIP_BITS-1:0]    o_cur_clip,
    output logic [FRAME_BITS-1:0]            o_cur_frame,
    output logic [FRAME_BITS-1:0]            o_cur_next_frame,
    output logic [kpc_pkg::RATIO_BITS-1:0]   o_cur_ratio,
    output logic [kpc_pkg::CLIP_BITS-1:0]    o_prev_clip,
    output logic [FRAME_BITS-1:0]            o_prev_frame,
    output logic [FRAME_BITS-1:0]            o_prev_next_frame,
    output logic [kpc_pkg::RATIO_BITS-1:0]   o_prev_ratio,
    output logic                             o_fading,
    output logic                             o_finished
);
    import kpc_pkg::*;

    localparam int TW1 = TIME_BITS + 1;
    localparam int PW  = TIME_BITS + FRAME_BITS;
    localparam int DW  = PW + FRAC_BITS;
    localparam int QW  = FRAME_BITS + FRAC_BITS + 1;
    localparam int FW1 = FRAME_BITS + 1;
    localparam int CW  = $clog2(DW + 1);

    logic                  r_in_cmd;
    logic [TIME_BITS-1:0]  r_in_delta;
    logic [CLIP_BITS-1:0]  r_in_clip;
    logic [TIME_BITS-1:0]  r_in_len;
    logic [FRAME_BITS-1:0] r_in_frm;
    logic                  r_in_loop;
    logic [TIME_BITS-1:0]  r_in_fade;

    logic [CLIP_BITS-1:0]  r_clip [2];
    logic [TIME_BITS-1:0]  r_len  [2];
    logic [FRAME_BITS-1:0] r_frm  [2];
    logic                  r_loop [2];
    logic [TIME_BITS-1:0]  r_time [2];
    logic [FRAME_BITS-1:0] r_fr   [2];
    logic [FRAME_BITS-1:0] r_nx   [2];
    logic [RATIO_BITS-1:0] r_rat  [2];

    logic                  r_cur_valid;
    logic [TW1-1:0]        r_fel;
    logic [TIME_BITS-1:0]  r_ftot;
    logic                  r_fin;
    logic                  r_ign;

    logic [TW1-1:0]        r_wtime;
    logic                  r_wrap;
    logic [DW-1:0]         r_dq;
    logic [TW1-1:0]        r_rem;
    logic [CW-1:0]         r_cnt;

    logic [TIME_BITS-1:0]  len_s;
    logic [FRAME_BITS-1:0] frm_s;
    logic                  loop_s;
    logic [TW1-1:0]        tsum;
    logic                  over;
    logic                  frozen;
    logic                  ign_cond;
    logic [TW1-1:0]        rem_sh;
    logic                  ge;
    logic [TIME_BITS-1:0]  tt;
    logic [PW-1:0]         prod;
    logic [QW-1:0]         q;
    logic [FW1-1:0]        fr;
    logic [FW1-1:0]        fm1;
    logic [FW1-1:0]        frc;
    logic [FRAME_BITS-1:0] nx;
    logic [QW-1:0]         rfull;
    logic [RATIO_BITS-1:0] rat;
    logic [TW1-1:0]        fel_sum;

    always_comb begin
        len_s    = r_len[i_cmd.sel];
        frm_s    = r_frm[i_cmd.sel];
        loop_s   = r_loop[i_cmd.sel];
        tsum     = {1'b0, r_time[i_cmd.sel]} + {1'b0, r_in_delta};
        over     = tsum >= {1'b0, len_s};
        frozen   = (len_s == '0) || (frm_s == '0);
        ign_cond = r_cur_valid && (r_in_clip == r_clip[CH_CUR]) && (r_ftot == '0);
        rem_sh   = {r_rem[TIME_BITS-1:0], r_dq[DW-1]};
        ge       = rem_sh >= {1'b0, len_s};
        tt       = r_wrap ? r_rem[TIME_BITS-1:0] : r_wtime[TIME_BITS-1:0];
        prod     = PW'(tt) * PW'(frm_s);
        q        = r_dq[QW-1:0];
        fr       = q[QW-1:FRAC_BITS];
        fm1      = {1'b0, frm_s} - FW1'(1);
        frc      = (fr > fm1) ? fm1 : fr;
        if (frc >= fm1) begin
            nx = loop_s ? '0 : fm1[FRAME_BITS-1:0];
        end else begin
            nx = frc[FRAME_BITS-1:0] + FRAME_BITS'(1);
        end
        rfull    = q - {frc, {FRAC_BITS{1'b0}}};
        rat      = (rfull > QW'(Q_ONE)) ? Q_ONE : rfull[RATIO_BITS-1:0];
        fel_sum  = r_fel + {1'b0, r_in_delta};
    end

    assign o_stat.command  = r_in_cmd;
    assign o_stat.frozen   = frozen;
    assign o_stat.wrap     = !frozen && over && loop_s;
    assign o_stat.div_last = (r_cnt == CW'(1));
    assign o_stat.fading   = (r_ftot != '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_in_cmd   <= i_command;
            r_in_delta <= i_delta_time;
            r_in_clip  <= i_clip_id;
            r_in_len   <= i_clip_length;
            r_in_frm   <= i_clip_frames;
            r_in_loop  <= i_loop_enable;
            r_in_fade  <= i_fade_time;
        end
        if (i_cmd.add) begin
            r_wtime <= (over && !loop_s) ? {1'b0, len_s} : tsum;
            r_wrap  <= !frozen && over && loop_s;
            r_dq    <= {tsum, {(DW-TW1){1'b0}}};
            r_rem   <= '0;
            r_cnt   <= CW'(TW1);
        end else if (i_cmd.mul) begin
            r_dq  <= {prod, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_cnt <= CW'(DW);
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? (rem_sh - {1'b0, len_s}) : rem_sh;
            r_dq  <= {r_dq[DW-2:0], ge};
            r_cnt <= r_cnt - CW'(1);
        end
        if (i_cmd.out_load) begin
            o_start_ignored   <= r_ign;
            o_cur_clip        <= r_clip[CH_CUR];
            o_cur_frame       <= r_fr[CH_CUR];
            o_cur_next_frame  <= r_nx[CH_CUR];
            o_cur_ratio       <= r_rat[CH_CUR];
            o_prev_clip       <= r_clip[CH_PREV];
            o_prev_frame      <= r_fr[CH_PREV];
            o_prev_next_frame <= r_nx[CH_PREV];
            o_prev_ratio      <= r_rat[CH_PREV];
            o_fading          <= (r_ftot != '0);
            o_finished        <= r_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2; i++) begin
                r_clip[i] <= '0;
                r_len[i]  <= '0;
                r_frm[i]  <= '0;
                r_loop[i] <= 1'b0;
                r_time[i] <= '0;
                r_fr[i]   <= '0;
                r_nx[i]   <= '0;
                r_rat[i]  <= '0;
            end
            r_cur_valid <= 1'b0;
            r_fel       <= '0;
            r_ftot      <= '0;
            r_fin       <= 1'b0;
            r_ign       <= 1'b0;
        end else begin
            if (i_cmd.decide) begin
                r_ign <= (r_in_cmd == CMD_START) && ign_cond;
                if (r_in_cmd == CMD_START && !ign_cond) begin
                    if (r_in_fade != '0) begin
                        r_clip[CH_PREV] <= r_clip[CH_CUR];
                        r_len[CH_PREV]  <= r_len[CH_CUR];
                        r_frm[CH_PREV]  <= r_frm[CH_CUR];
                        r_loop[CH_PREV] <= r_loop[CH_CUR];
                        r_time[CH_PREV] <= r_time[CH_CUR];
                        r_fr[CH_PREV]   <= r_fr[CH_CUR];
                        r_nx[CH_PREV]   <= r_nx[CH_CUR];
                        r_rat[CH_PREV]  <= r_rat[CH_CUR];
                        r_fel           <= '0;
                    end
                    r_ftot         <= r_in_fade;
                    r_cur_valid    <= 1'b1;
                    r_clip[CH_CUR] <= r_in_clip;
                    r_len[CH_CUR]  <= r_in_len;
                    r_frm[CH_CUR]  <= r_in_frm;
                    r_loop[CH_CUR] <= r_in_loop;
                    r_time[CH_CUR] <= '0;
                    r_fr[CH_CUR]   <= '0;
                    r_nx[CH_CUR]   <= '0;
                    r_rat[CH_CUR]  <= '0;
                    r_fin          <= 1'b0;
                end
            end
            if (i_cmd.add && i_cmd.sel == CH_CUR) begin
                r_fin <= !frozen && over && !loop_s;
            end
            if (i_cmd.mul) begin
                r_time[i_cmd.sel] <= tt;
            end
            if (i_cmd.pos) begin
                r_fr[i_cmd.sel]  <= frc[FRAME_BITS-1:0];
                r_nx[i_cmd.sel]  <= nx;
                r_rat[i_cmd.sel] <= rat;
            end
            if (i_cmd.fade && r_ftot != '0) begin
                r_fel <= fel_sum;
                if (fel_sum >= {1'b0, r_ftot}) begin
                    r_ftot <= '0;
                end
            end
        end
    end

endmodule

>>> design/keyframe_playback_crossfade.sv
// Keyframe playback timer with crossfade. A start item loads a clip into the
// current channel (copying the old one to the previous channel when fade_time
// is nonzero) unless it names the current clip while no fade runs, in which
// case it only flags the start as ignored; a tick item advances the current
// channel and, during a fade, the previous one. Every item returns one result
// item, and one item is handled at a time. A start passes the decide and
// output states; a tick passes the decide state, then per channel an add
// step and, unless the channel is frozen, TIME_BITS+1 modulo steps when the
// time wraps, a multiply, TIME_BITS+FRAME_BITS+16 divide steps of the single
// shared restoring divider and a position update, then fade and output states.
// A stalled output holds back the next result, not acceptance of the next item.
module keyframe_playback_crossfade #(
    parameter int TIME_BITS  = 24,
    parameter int FRAME_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_command,
    input  logic [TIME_BITS-1:0]             i_delta_time,
    input  logic [kpc_pkg::CLIP_BITS-1:0]    i_clip_id,
    input  logic [TIME_BITS-1:0]             i_clip_length,
    input  logic [FRAME_BITS-1:0]            i_clip_frames,
    input  logic                             i_loop_enable,
    input  logic [TIME_BITS-1:0]             i_fade_time,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_start_ignored,
    output logic [kpc_pkg::CLIP_BITS-1:0]    o_cur_clip,
    output logic [FRAME_BITS-1:0]            o_cur_frame,
    output logic [FRAME_BITS-1:0]            o_cur_next_frame,
    output logic [kpc_pkg::RATIO_BITS-1:0]   o_cur_ratio,
    output logic [kpc_pkg::CLIP_BITS-1:0]    o_prev_clip,
    output logic [FRAME_BITS-1:0]            o_prev_frame,
    output logic [FRAME_BITS-1:0]            o_prev_next_frame,
    output logic [kpc_pkg::RATIO_BITS-1:0]   o_prev_ratio,
    output logic                             o_fading,
    output logic                             o_finished
);
    import kpc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    kpc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    kpc_dp #(
        .TIME_BITS  (TIME_BITS),
        .FRAME_BITS (FRAME_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_command         (i_command),
        .i_delta_time      (i_delta_time),
        .i_clip_id         (i_clip_id),
        .i_clip_length     (i_clip_length),
        .i_clip_frames     (i_clip_frames),
        .i_loop_enable     (i_loop_enable),
        .i_fade_time       (i_fade_time),
        .o_start_ignored   (o_start_ignored),
        .o_cur_clip        (o_cur_clip),
        .o_cur_frame       (o_cur_frame),
        .o_cur_next_frame  (o_cur_next_frame),
        .o_cur_ratio       (o_cur_ratio),
        .o_prev_clip       (o_prev_clip),
        .o_prev_frame      (o_prev_frame),
        .o_prev_next_frame (o_prev_next_frame),
        .o_prev_ratio      (o_prev_ratio),
        .o_fading          (o_fading),
        .o_finished        (o_finished)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input accepted while not busy afterwards");

    a_cur_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_cur_ratio <= Q_ONE)
        else $error("current ratio above one");

    a_prev_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_prev_ratio <= Q_ONE)
        else $error("previous ratio above one");

endmodule
